// File: rtl/rsd_pkg.sv
// shared constants for the radial stick deadzone block
package rsd_pkg;

  localparam logic [14:0] FULL_SCALE = 15'd32767;

  localparam int SQ_W    = 32;
  localparam int ROOT_W  = 16;
  localparam int REM_W   = 20;
  localparam int DEN_W   = 31;
  localparam int NUM_W   = 46;
  localparam int QUO_W   = 16;
  localparam int SQRT_STEPS = SQ_W / 2;
  localparam int DIV_STEPS  = QUO_W;

  // square, sum, root cells, scale, two multiplies, divide cells, output
  localparam int STICK_LAT = 2 + SQRT_STEPS + 3 + DIV_STEPS + 1;

  localparam logic CFG_INNER = 1'b0;
  localparam logic CFG_OUTER = 1'b1;

  localparam logic [14:0] INNER_RESET = 15'd3277;
  localparam logic [14:0] OUTER_RESET = 15'd29490;

endpackage

// File: rtl/rsd_sqrt_cell.sv
// one digit step of the integer square root chain
module rsd_sqrt_cell import rsd_pkg::*; #(
  parameter int PW = 32
) (
  input  logic              clk,
  input  logic              en,
  input  logic [REM_W-1:0]  rem_i,
  input  logic [ROOT_W-1:0] root_i,
  input  logic [SQ_W-1:0]   s_i,
  input  logic [PW-1:0]     pl_i,
  output logic [REM_W-1:0]  rem_o,
  output logic [ROOT_W-1:0] root_o,
  output logic [SQ_W-1:0]   s_o,
  output logic [PW-1:0]     pl_o
);

  logic [REM_W-1:0]  rs;
  logic [REM_W-1:0]  tr;
  logic              ge;
  logic [REM_W-1:0]  rem_nxt;
  logic [ROOT_W-1:0] root_nxt;

  always_comb begin
    rs       = {rem_i[REM_W-3:0], s_i[SQ_W-1 -: 2]};
    tr       = REM_W'({root_i, 2'b01});
    ge       = (rs >= tr);
    rem_nxt  = ge ? (rs - tr) : rs;
    root_nxt = {root_i[ROOT_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_o  <= rem_nxt;
      root_o <= root_nxt;
      s_o    <= {s_i[SQ_W-3:0], 2'b00};
      pl_o   <= pl_i;
    end
  end

endmodule

// File: rtl/rsd_div_cell.sv
// one quotient bit step of the restoring divide chain
module rsd_div_cell import rsd_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  logic [DEN_W-1:0]  r_i,
  input  logic [QUO_W-1:0]  q_i,
  input  logic [QUO_W-1:0]  p_i,
  input  logic [DEN_W-1:0]  den_i,
  input  logic              sgn_i,
  output logic [DEN_W-1:0]  r_o,
  output logic [QUO_W-1:0]  q_o,
  output logic [QUO_W-1:0]  p_o,
  output logic [DEN_W-1:0]  den_o,
  output logic              sgn_o
);

  logic [DEN_W:0]   r2;
  logic [DEN_W:0]   dx;
  logic             ge;
  logic [DEN_W:0]   diff;
  logic [DEN_W-1:0] r_nxt;

  always_comb begin
    r2    = {r_i, p_i[QUO_W-1]};
    dx    = {1'b0, den_i};
    ge    = (r2 >= dx);
    diff  = r2 - dx;
    r_nxt = ge ? diff[DEN_W-1:0] : r2[DEN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r_o   <= r_nxt;
      q_o   <= {q_i[QUO_W-2:0], ge};
      p_o   <= {p_i[QUO_W-2:0], 1'b0};
      den_o <= den_i;
      sgn_o <= sgn_i;
    end
  end

endmodule

// File: rtl/rsd_stick.sv
// deadzone scaling pipeline for one stick
module rsd_stick import rsd_pkg::*; (
  input  logic               clk,
  input  logic               en,
  input  logic signed [15:0] x_i,
  input  logic signed [15:0] y_i,
  input  logic [14:0]        inner_i,
  input  logic [14:0]        outer_i,
  output logic signed [15:0] x_o,
  output logic signed [15:0] y_o
);

  // squares
  logic signed [31:0] xs, ys;
  logic [31:0] xx_r, yy_r;
  logic [31:0] pa_r;
  assign xs = x_i * x_i;
  assign ys = y_i * y_i;

  always_ff @(posedge clk) begin
    if (en) begin
      xx_r <= unsigned'(xs);
      yy_r <= unsigned'(ys);
      pa_r <= {x_i, y_i};
    end
  end

  // sum
  logic [SQ_W-1:0] s_r;
  logic [31:0]     pb_r;
  always_ff @(posedge clk) begin
    if (en) begin
      s_r  <= xx_r + yy_r;
      pb_r <= pa_r;
    end
  end

  // root cells
  logic [REM_W-1:0]  rem  [0:SQRT_STEPS];
  logic [ROOT_W-1:0] root [0:SQRT_STEPS];
  logic [SQ_W-1:0]   sv   [0:SQRT_STEPS];
  logic [31:0]       pl   [0:SQRT_STEPS];

  assign rem[0]  = '0;
  assign root[0] = '0;
  assign sv[0]   = s_r;
  assign pl[0]   = pb_r;

  for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_sqrt
    rsd_sqrt_cell #(.PW(32)) u_cell (
      .clk    (clk),
      .en     (en),
      .rem_i  (rem[i]),
      .root_i (root[i]),
      .s_i    (sv[i]),
      .pl_i   (pl[i]),
      .rem_o  (rem[i+1]),
      .root_o (root[i+1]),
      .s_o    (sv[i+1]),
      .pl_o   (pl[i+1])
    );
  end

  // scale terms
  logic [ROOT_W-1:0] m;
  logic [15:0]       xr, yr;
  logic              gt;
  logic [14:0]       dd;
  logic [15:0]       diff;
  logic [14:0]       n_nxt, d_nxt;
  logic [15:0]       m_nxt;
  logic [15:0]       ax_nxt, ay_nxt;

  always_comb begin
    m     = root[SQRT_STEPS];
    xr    = pl[SQRT_STEPS][31:16];
    yr    = pl[SQRT_STEPS][15:0];
    gt    = (m > {1'b0, inner_i});
    dd    = outer_i - inner_i;
    diff  = m - {1'b0, inner_i};
    n_nxt = '0;
    d_nxt = 15'd1;
    if (outer_i > inner_i) begin
      d_nxt = dd;
      if (gt) begin
        n_nxt = (diff > {1'b0, dd}) ? dd : diff[14:0];
      end
    end else begin
      n_nxt = {14'd0, gt};
    end
    m_nxt  = (m == '0) ? 16'd1 : m;
    ax_nxt = xr[15] ? (~xr + 16'd1) : xr;
    ay_nxt = yr[15] ? (~yr + 16'd1) : yr;
  end

  logic [14:0] nc_r, dc_r;
  logic [15:0] mc_r, ax_r, ay_r;
  logic        sxc_r, syc_r;
  always_ff @(posedge clk) begin
    if (en) begin
      nc_r  <= n_nxt;
      dc_r  <= d_nxt;
      mc_r  <= m_nxt;
      ax_r  <= ax_nxt;
      ay_r  <= ay_nxt;
      sxc_r <= xr[15];
      syc_r <= yr[15];
    end
  end

  // axis times offset, deadzone span times magnitude
  logic [DEN_W-1:0] p1x_r, p1y_r, dend_r;
  logic             sxd_r, syd_r;
  always_ff @(posedge clk) begin
    if (en) begin
      p1x_r  <= ax_r * nc_r;
      p1y_r  <= ay_r * nc_r;
      dend_r <= dc_r * mc_r;
      sxd_r  <= sxc_r;
      syd_r  <= syc_r;
    end
  end

  // times full scale
  logic [NUM_W-1:0] px_r, py_r;
  logic [DEN_W-1:0] dene_r;
  logic             sxe_r, sye_r;
  always_ff @(posedge clk) begin
    if (en) begin
      px_r   <= p1x_r * FULL_SCALE;
      py_r   <= p1y_r * FULL_SCALE;
      dene_r <= dend_r;
      sxe_r  <= sxd_r;
      sye_r  <= syd_r;
    end
  end

  // divide cells, one chain per axis
  logic [DEN_W-1:0] rx [0:DIV_STEPS];
  logic [QUO_W-1:0] qx [0:DIV_STEPS];
  logic [QUO_W-1:0] ppx [0:DIV_STEPS];
  logic [DEN_W-1:0] dx [0:DIV_STEPS];
  logic             gx [0:DIV_STEPS];
  logic [DEN_W-1:0] ry [0:DIV_STEPS];
  logic [QUO_W-1:0] qy [0:DIV_STEPS];
  logic [QUO_W-1:0] ppy [0:DIV_STEPS];
  logic [DEN_W-1:0] dy [0:DIV_STEPS];
  logic             gy [0:DIV_STEPS];

  assign rx[0]  = DEN_W'(px_r[NUM_W-1:QUO_W]);
  assign qx[0]  = '0;
  assign ppx[0] = px_r[QUO_W-1:0];
  assign dx[0]  = dene_r;
  assign gx[0]  = sxe_r;
  assign ry[0]  = DEN_W'(py_r[NUM_W-1:QUO_W]);
  assign qy[0]  = '0;
  assign ppy[0] = py_r[QUO_W-1:0];
  assign dy[0]  = dene_r;
  assign gy[0]  = sye_r;

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
    rsd_div_cell u_x (
      .clk   (clk),
      .en    (en),
      .r_i   (rx[i]),
      .q_i   (qx[i]),
      .p_i   (ppx[i]),
      .den_i (dx[i]),
      .sgn_i (gx[i]),
      .r_o   (rx[i+1]),
      .q_o   (qx[i+1]),
      .p_o   (ppx[i+1]),
      .den_o (dx[i+1]),
      .sgn_o (gx[i+1])
    );
    rsd_div_cell u_y (
      .clk   (clk),
      .en    (en),
      .r_i   (ry[i]),
      .q_i   (qy[i]),
      .p_i   (ppy[i]),
      .den_i (dy[i]),
      .sgn_i (gy[i]),
      .r_o   (ry[i+1]),
      .q_o   (qy[i+1]),
      .p_o   (ppy[i+1]),
      .den_o (dy[i+1]),
      .sgn_o (gy[i+1])
    );
  end

  // saturate and restore sign
  logic [15:0] qxs, qys;
  logic [15:0] x_nxt, y_nxt;
  always_comb begin
    qxs   = (qx[DIV_STEPS] > 16'd32767) ? 16'd32767 : qx[DIV_STEPS];
    qys   = (qy[DIV_STEPS] > 16'd32767) ? 16'd32767 : qy[DIV_STEPS];
    x_nxt = gx[DIV_STEPS] ? (~qxs + 16'd1) : qxs;
    y_nxt = gy[DIV_STEPS] ? (~qys + 16'd1) : qys;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_o <= signed'(x_nxt);
      y_o <= signed'(y_nxt);
    end
  end

endmodule

// File: rtl/radial_stick_deadzone.sv
// top level: radial deadzone scaling of two sticks and trigger clamping
// throughput: one sample per cycle while no held result stalls the pipeline,
// set by the fully pipelined root and divide cell chains
// a held result stalls the whole pipeline and the input side with it
// reset: synchronous active low, clears valid bits and loads default deadzones
// deadzone registers reset to 3277 inner and 29490 outer
module radial_stick_deadzone import rsd_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] in_left_x_raw,
  input  logic signed [15:0] in_left_y_raw,
  input  logic signed [15:0] in_right_x_raw,
  input  logic signed [15:0] in_right_y_raw,
  input  logic signed [15:0] in_left_trigger_raw,
  input  logic signed [15:0] in_right_trigger_raw,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_left_x_out,
  output logic signed [15:0] out_left_y_out,
  output logic signed [15:0] out_right_x_out,
  output logic signed [15:0] out_right_y_out,
  output logic [14:0]        out_left_trigger_out,
  output logic [14:0]        out_right_trigger_out,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [14:0]        cfg_wdata
);

  logic [14:0] inner_r, outer_r;
  logic        en;
  logic        vld_r [0:STICK_LAT-1];
  logic [14:0] lt_r  [0:STICK_LAT-1];
  logic [14:0] rt_r  [0:STICK_LAT-1];
  logic [14:0] lt_nxt, rt_nxt;

  assign en        = !(vld_r[STICK_LAT-1] && out_stall);
  assign in_stall  = !en;
  assign out_valid = vld_r[STICK_LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inner_r <= INNER_RESET;
      outer_r <= OUTER_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_INNER: inner_r <= cfg_wdata;
        CFG_OUTER: outer_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    lt_nxt = in_left_trigger_raw[15] ? 15'd0 :
             ((in_left_trigger_raw[14:0] > FULL_SCALE) ? FULL_SCALE
                                                        : in_left_trigger_raw[14:0]);
    rt_nxt = in_right_trigger_raw[15] ? 15'd0 :
             ((in_right_trigger_raw[14:0] > FULL_SCALE) ? FULL_SCALE
                                                         : in_right_trigger_raw[14:0]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < STICK_LAT; i++) begin
        vld_r[i] <= 1'b0;
      end
    end else if (en) begin
      vld_r[0] <= in_valid;
      for (int i = 1; i < STICK_LAT; i++) begin
        vld_r[i] <= vld_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lt_r[0] <= lt_nxt;
      rt_r[0] <= rt_nxt;
      for (int i = 1; i < STICK_LAT; i++) begin
        lt_r[i] <= lt_r[i-1];
        rt_r[i] <= rt_r[i-1];
      end
    end
  end

  assign out_left_trigger_out  = lt_r[STICK_LAT-1];
  assign out_right_trigger_out = rt_r[STICK_LAT-1];

  rsd_stick u_left (
    .clk     (clk),
    .en      (en),
    .x_i     (in_left_x_raw),
    .y_i     (in_left_y_raw),
    .inner_i (inner_r),
    .outer_i (outer_r),
    .x_o     (out_left_x_out),
    .y_o     (out_left_y_out)
  );

  rsd_stick u_right (
    .clk     (clk),
    .en      (en),
    .x_i     (in_right_x_raw),
    .y_i     (in_right_y_raw),
    .inner_i (inner_r),
    .outer_i (outer_r),
    .x_o     (out_right_x_out),
    .y_o     (out_right_y_out)
  );

endmodule

// File: dv/radial_stick_deadzone_tb.sv
// self-checking testbench for the radial stick deadzone block
`timescale 1ns / 1ps

module radial_stick_deadzone_tb import rsd_pkg::*;;

  typedef struct packed {
    logic signed [15:0] lx, ly, rx, ry;
    logic [14:0]        lt, rt;
  } sample_out_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [15:0] in_lx = '0, in_ly = '0, in_rx = '0, in_ry = '0;
  logic signed [15:0] in_lt = '0, in_rt = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [15:0] o_lx, o_ly, o_rx, o_ry;
  logic [14:0] o_lt, o_rt;
  logic cfg_we = 1'b0;
  logic cfg_index = CFG_INNER;
  logic [14:0] cfg_wdata = '0;

  logic [14:0] inner_dz = INNER_RESET;
  logic [14:0] outer_dz = OUTER_RESET;
  sample_out_t pending_samples[$];
  int errors = 0;
  bit calm = 1'b0;

  radial_stick_deadzone dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_left_x_raw(in_lx), .in_left_y_raw(in_ly),
    .in_right_x_raw(in_rx), .in_right_y_raw(in_ry),
    .in_left_trigger_raw(in_lt), .in_right_trigger_raw(in_rt),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_left_x_out(o_lx), .out_left_y_out(o_ly),
    .out_right_x_out(o_rx), .out_right_y_out(o_ry),
    .out_left_trigger_out(o_lt), .out_right_trigger_out(o_rt),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  function automatic longint isqrt(longint s);
    longint r;
    r = 0;
    for (int b = 16; b >= 0; b--)
      if ((r + (64'sd1 << b)) * (r + (64'sd1 << b)) <= s) r = r + (64'sd1 << b);
    return r;
  endfunction

  function automatic logic signed [15:0] scale_axis(longint a, longint num, longint den);
    longint q;
    q = ((a < 0 ? -a : a) * num) / den;
    if (a < 0) q = -q;
    if (q > 32767) q = 32767;
    if (q < -32767) q = -32767;
    return q[15:0];
  endfunction

  task automatic predict_stick(input logic signed [15:0] x, y,
                               output logic signed [15:0] ox, oy);
    longint s, m, d, n, num, den;
    s = longint'(x) * x + longint'(y) * y;
    if (s == 0) begin
      ox = 0; oy = 0;
      return;
    end
    m = isqrt(s);
    if (outer_dz > inner_dz) begin
      d = outer_dz - inner_dz;
      n = (m > inner_dz) ? m - inner_dz : 0;
      if (n > d) n = d;
      num = n * FULL_SCALE;
      den = d * m;
    end else begin
      num = (m > inner_dz) ? FULL_SCALE : 0;
      den = m;
    end
    ox = scale_axis(x, num, den);
    oy = scale_axis(y, num, den);
  endtask

  function automatic logic [14:0] clamp_trigger(logic signed [15:0] t);
    return t < 0 ? 15'd0 : t[14:0];
  endfunction

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d want %0d", what, got, want);
    errors++;
  endtask

  task automatic send_sample(input logic signed [15:0] lx, ly, rx, ry, lt, rt);
    sample_out_t e;
    while (!calm && $urandom_range(99) < 37) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_lx <= lx; in_ly <= ly; in_rx <= rx; in_ry <= ry; in_lt <= lt; in_rt <= rt;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_stick(lx, ly, e.lx, e.ly);
    predict_stick(rx, ry, e.rx, e.ry);
    e.lt = clamp_trigger(lt);
    e.rt = clamp_trigger(rt);
    pending_samples.push_back(e);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk);
    repeat (STICK_LAT + 4) @(posedge clk);
  endtask

  task automatic write_deadzones(input logic [14:0] inner, outer);
    drain();
    cfg_we <= 1'b1; cfg_index <= CFG_INNER; cfg_wdata <= inner;
    @(posedge clk);
    cfg_index <= CFG_OUTER; cfg_wdata <= outer;
    @(posedge clk);
    cfg_we <= 1'b0;
    inner_dz = inner;
    outer_dz = outer;
  endtask

  always @(posedge clk) begin
    sample_out_t e;
    if (rst_n) out_stall <= !calm && ($urandom_range(99) < 37);
    if (rst_n && out_valid && !out_stall) begin
      if (pending_samples.size() == 0) begin
        report("unexpected transfer", 0, 0);
      end else begin
        e = pending_samples.pop_front();
        if (o_lx !== e.lx) report("left_x", o_lx, e.lx);
        if (o_ly !== e.ly) report("left_y", o_ly, e.ly);
        if (o_rx !== e.rx) report("right_x", o_rx, e.rx);
        if (o_ry !== e.ry) report("right_y", o_ry, e.ry);
        if (o_lt !== e.lt) report("left_trigger", o_lt, e.lt);
        if (o_rt !== e.rt) report("right_trigger", o_rt, e.rt);
      end
    end
  end

  function automatic logic signed [15:0] rand_axis();
    case ($urandom_range(5))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'($urandom_range(8)) - 16'sd4;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic test_extremes;
    send_sample(0, 0, 0, 0, 0, 0);
    send_sample(-32768, -32768, 32767, 32767, -32768, 32767);
    send_sample(-32768, 0, 0, -32768, -1, 1);
    send_sample(32767, 0, 0, 32767, 16'sh4000, -16'sh4000);
    send_sample(3277, 0, 3278, 0, 100, 0);
    send_sample(29490, 0, 0, -29489, 0, 0);
    send_sample(1, 1, -1, 1, 0, 0);
    send_sample(20000, -20000, -1000, 2500, 12345, -5);
  endtask

  task automatic test_deadzone_settings;
    logic [14:0] sets[6][2] = '{'{0, 32767}, '{32767, 0}, '{5000, 5000},
                                 '{0, 0}, '{32767, 32767}, '{100, 200}};
    for (int i = 0; i < 6; i++) begin
      write_deadzones(sets[i][0], sets[i][1]);
      send_sample(-32768, 32767, 0, 0, 0, 0);
      send_sample(16'(sets[i][0]), 0, 0, 16'(sets[i][0]) + 16'd1, 0, 0);
      send_sample(1, 0, 0, -1, 0, 0);
    end
    write_deadzones(INNER_RESET, OUTER_RESET);
  endtask

  task automatic test_random;
    for (int i = 0; i < 1100; i++) begin
      if (i % 200 == 199) write_deadzones(15'($urandom), 15'($urandom));
      if (i == 500) calm = 1'b1;
      if (i == 650) calm = 1'b0;
      if (i == 800) drain();
      send_sample(rand_axis(), rand_axis(), rand_axis(), rand_axis(),
                  rand_axis(), rand_axis());
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_extremes();
    test_deadzone_settings();
    test_random();
    drain();
    if (errors == 0) $display("radial_stick_deadzone regression: pass");
    else $display("radial_stick_deadzone regression: fail");
    $finish;
  end

  initial begin
    #5ms;
    $display("radial_stick_deadzone regression: fail");
    $finish;
  end

endmodule
